// ===== hdl/hsv_to_rgb_converter_top_defines.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define HSVC_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define HSVC_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/hsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Constants, codes and shared types of the converter.
// ----------------------------------------------------------------------------
package hsvc_pkg;

   localparam int HUE_W      = 9;
   localparam int CHAN_W     = 8;
   localparam int FRAC_W     = 7;
   localparam int NUM_W      = 14;
   localparam int PROD_W     = 22;
   localparam int RECIP_W    = 23;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [HUE_W-1:0]  HUE_FULL_TURN  = 9'd360;
   localparam logic [FRAC_W-1:0] SECTOR_DEGREES = 7'd60;
   // 255 * 60: common denominator of all three levels
   localparam logic [NUM_W-1:0]  FRAC_SCALE     = 14'd15300;
   // ceil(2^36 / 15300); exact floor division for every product below 2^22
   localparam logic [RECIP_W-1:0] RECIP_MULT    = 23'd4491470;
   localparam int RECIP_SHIFT = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_SATURATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = 1'b1;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW   = 3'd0,
      SECTOR_YELLOW_GREEN = 3'd1,
      SECTOR_GREEN_CYAN   = 3'd2,
      SECTOR_CYAN_BLUE    = 3'd3,
      SECTOR_BLUE_MAGENTA = 3'd4,
      SECTOR_MAGENTA_RED  = 3'd5
   } sector_type;

   // Load strobes for the three stages of a level lane.
   typedef struct packed {
      logic num;
      logic prod;
      logic quot;
   } lvl_adv_type;

endpackage

// ===== hdl/hsvc_level.sv =====
// ----------------------------------------------------------------------------
// HSV level lane
// Three-stage pipe: floor(v * (15300 - s*frac) / 15300).
// ----------------------------------------------------------------------------
module hsvc_level (
   input  logic                        clock,
   input  hsvc_pkg::lvl_adv_type       adv,
   input  logic [hsvc_pkg::CHAN_W-1:0] sat,
   input  logic [hsvc_pkg::CHAN_W-1:0] bri,
   input  logic [hsvc_pkg::FRAC_W-1:0] frac,
   output logic [hsvc_pkg::CHAN_W-1:0] level
);
   import hsvc_pkg::*;

   logic [CHAN_W+FRAC_W-1:0]      sat_frac;
   logic [NUM_W-1:0]              num_in, num_ff;
   logic [PROD_W-1:0]             prod_in, prod_ff;
   logic [PROD_W+RECIP_W-1:0]     recip_prod;
   logic [CHAN_W-1:0]             quot_in, quot_ff;

   // frac never exceeds 60, so s*frac never exceeds the scale
   assign sat_frac = (CHAN_W+FRAC_W)'(sat) * (CHAN_W+FRAC_W)'(frac);
   assign num_in   = NUM_W'((CHAN_W+FRAC_W)'(FRAC_SCALE) - sat_frac);
   assign prod_in  = PROD_W'(bri) * PROD_W'(num_ff);

   // divide by 15300 through the reciprocal; quotient fits in a channel
   assign recip_prod = (PROD_W+RECIP_W)'(prod_ff) * (PROD_W+RECIP_W)'(RECIP_MULT);
   assign quot_in    = recip_prod[RECIP_SHIFT +: CHAN_W];

   always_ff @(posedge clock) begin
      if (adv.num) begin
         num_ff <= num_in;
      end
      if (adv.prod) begin
         prod_ff <= prod_in;
      end
      if (adv.quot) begin
         quot_ff <= quot_in;
      end
   end

   assign level = quot_ff;

endmodule

// ===== hdl/hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Streams hues in whole degrees and returns 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Each transfer on the req_ side carries one hue (0..360; 360 reads as 0 and
// 361..511 wrap by subtracting 360). Saturation and brightness are taken from
// two registers written through the csr_ port (index 0 saturation, index 1
// brightness, both reset to 255); write them only while no hue is in flight.
// Every hue yields exactly one rsp_ transfer, in order. The six-stage pipeline
// takes a new hue every cycle while the output is not stalled; its longest
// stages are the 22 x 23 bit reciprocal multiply that replaces the divide by
// 15300 and the 8 x 14 bit level product, one of each per level lane. Each
// stage loads whenever it is empty or its successor moves, so bubbles close
// up under back-pressure and req_tready drops only when all six stages hold
// data and rsp_tready is low.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [hsvc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsvc_pkg::CHAN_W-1:0]       csr_wr_data,
   // hue stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hsvc_pkg::REQ_DATA_W-1:0]   req_tdata,  // [8:0] hue, [15:9] zero
   // color stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hsvc_pkg::RSP_DATA_W-1:0]   rsp_tdata   // [7:0] red, [15:8] green,
                                                         // [23:16] blue
);
   import hsvc_pkg::*;

   localparam int STAGES = 6;

   // configuration registers
   logic [CHAN_W-1:0] sat_ff, sat_in;
   logic [CHAN_W-1:0] bri_ff, bri_in;

   // per-stage valid and load control
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_rdy;

   // stage 1: wrapped hue
   logic [HUE_W-1:0]  hue_raw;
   logic [HUE_W-1:0]  hue_in, hue_ff;

   // stage 2: sector and fraction
   sector_type        sector_in;
   logic [HUE_W-1:0]  sector_base;
   logic [FRAC_W-1:0] fm_in, fm_ff;
   logic [FRAC_W-1:0] fmc_in, fmc_ff;

   // sector travels beside the level lanes (stages 2..5)
   sector_type        sector_ff [4];

   // level lanes
   lvl_adv_type       lane_adv;
   logic [CHAN_W-1:0] lvl_p, lvl_q, lvl_t;

   // stage 6: output register
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [RSP_DATA_W-1:0] rsp_data_in, rsp_data_ff;

   // ---------------------------------------------------------------- config
   always_comb begin
      sat_in = sat_ff;
      bri_in = bri_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SATURATION: sat_in = csr_wr_data;
            CSR_BRIGHTNESS: bri_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= '1;
         bri_ff <= '1;
      end else begin
         sat_ff <= sat_in;
         bri_ff <= bri_in;
      end
   end

   // ------------------------------------------------------------- handshake
   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      stage_rdy[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES-2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_rdy[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = stage_rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   // --------------------------------------------------------- stage 1: wrap
   assign hue_raw = req_tdata[HUE_W-1:0];
   assign hue_in  = (hue_raw >= HUE_FULL_TURN) ? hue_raw - HUE_FULL_TURN : hue_raw;

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         hue_ff <= hue_in;
      end
   end

   // ------------------------------------------------------- stage 2: sector
   // Pick the 60 degree sector by comparison; the remainder is the offset
   // from the sector's starting hue.
   always_comb begin
      priority if (hue_ff >= 9'd300) begin
         sector_in   = SECTOR_MAGENTA_RED;
         sector_base = 9'd300;
      end else if (hue_ff >= 9'd240) begin
         sector_in   = SECTOR_BLUE_MAGENTA;
         sector_base = 9'd240;
      end else if (hue_ff >= 9'd180) begin
         sector_in   = SECTOR_CYAN_BLUE;
         sector_base = 9'd180;
      end else if (hue_ff >= 9'd120) begin
         sector_in   = SECTOR_GREEN_CYAN;
         sector_base = 9'd120;
      end else if (hue_ff >= 9'd60) begin
         sector_in   = SECTOR_YELLOW_GREEN;
         sector_base = 9'd60;
      end else begin
         sector_in   = SECTOR_RED_YELLOW;
         sector_base = 9'd0;
      end
   end

   assign fm_in  = FRAC_W'(hue_ff - sector_base);
   assign fmc_in = SECTOR_DEGREES - fm_in;

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         fm_ff        <= fm_in;
         fmc_ff       <= fmc_in;
         sector_ff[0] <= sector_in;
      end
      if (stage_rdy[2]) begin
         sector_ff[1] <= sector_ff[0];
      end
      if (stage_rdy[3]) begin
         sector_ff[2] <= sector_ff[1];
      end
      if (stage_rdy[4]) begin
         sector_ff[3] <= sector_ff[2];
      end
   end

   // ----------------------------------------------- stages 3..5: level lanes
   // Hold each lane stage exactly when the matching valid stage holds.
   assign lane_adv.num  = stage_rdy[2];
   assign lane_adv.prod = stage_rdy[3];
   assign lane_adv.quot = stage_rdy[4];

   // p is the q form with a full fraction: v*(255-s)/255 == v*(15300-60s)/15300
   hsvc_level u_lvl_p (
      .clock (clock),
      .adv   (lane_adv),
      .sat   (sat_ff),
      .bri   (bri_ff),
      .frac  (SECTOR_DEGREES),
      .level (lvl_p)
   );

   hsvc_level u_lvl_q (
      .clock (clock),
      .adv   (lane_adv),
      .sat   (sat_ff),
      .bri   (bri_ff),
      .frac  (fm_ff),
      .level (lvl_q)
   );

   hsvc_level u_lvl_t (
      .clock (clock),
      .adv   (lane_adv),
      .sat   (sat_ff),
      .bri   (bri_ff),
      .frac  (fmc_ff),
      .level (lvl_t)
   );

   // ------------------------------------------------------- stage 6: select
   always_comb begin
      unique case (sector_ff[3])
         SECTOR_RED_YELLOW: begin
            red_in = bri_ff; green_in = lvl_t;  blue_in = lvl_p;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = lvl_q;  green_in = bri_ff; blue_in = lvl_p;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = lvl_p;  green_in = bri_ff; blue_in = lvl_t;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = lvl_p;  green_in = lvl_q;  blue_in = bri_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = lvl_t;  green_in = lvl_p;  blue_in = bri_ff;
         end
         default: begin
            red_in = bri_ff; green_in = lvl_p;  blue_in = lvl_q;
         end
      endcase
   end

   assign rsp_data_in = {blue_in, green_in, red_in};

   always_ff @(posedge clock) begin
      if (stage_rdy[5]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== hdl/hsvc_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter port checker
// Watches the converter's ports for occupancy, stall and color rules.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_defines.svh"

module hsvc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              csr_wr_en,
   input logic [hsvc_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [hsvc_pkg::CHAN_W-1:0]       csr_wr_data,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [hsvc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import hsvc_pkg::*;

   logic [2:0]        count_ff, count_in;
   logic [CHAN_W-1:0] bri_ff, bri_in;
   logic              acc_in, acc_out;

   assign acc_in  = req_tvalid && req_tready;
   assign acc_out = rsp_tvalid && rsp_tready;

   // items accepted and not yet delivered
   assign count_in = 3'(count_ff + 3'(acc_in) - 3'(acc_out));

   // shadow of the brightness register
   assign bri_in = (csr_wr_en && csr_index == CSR_BRIGHTNESS) ? csr_wr_data : bri_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bri_ff   <= '1;
      end else begin
         count_ff <= count_in;
         bri_ff   <= bri_in;
      end
   end

   `HSVC_CHECK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   `HSVC_CHECK(a_occupancy, 1'b1, count_ff <= 3'd6 && (!rsp_tvalid || count_ff != 3'd0), "in-flight count out of range")

   `HSVC_CHECK(a_full_stall, !req_tready, count_ff == 3'd6 && rsp_tvalid && !rsp_tready, "input stalled with room in the pipeline")

   `HSVC_CHECK(a_peak_channel, rsp_tvalid, rsp_tdata[7:0] == bri_ff || rsp_tdata[15:8] == bri_ff || rsp_tdata[23:16] == bri_ff, "no channel equals brightness")

endmodule

bind hsv_to_rgb_converter_top hsvc_checker u_hsvc_checker (.*);
